// File: rtl/cesd_pkg.sv
package cesd_pkg;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDigit0    = 8'h30;
  localparam logic [7:0] ChDigit7    = 8'h37;
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] CodeLf      = 8'h0A;
  localparam logic [7:0] CodeFf      = 8'h0C;
  localparam logic [7:0] CodeBs      = 8'h08;
  localparam logic [7:0] CodeCr      = 8'h0D;
  localparam logic [7:0] CodeHt      = 8'h09;

  // Result queue depth: one slot holds the result in flight, two take a new item.
  localparam int QueueDepth = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // Results of one decoded character, in order; cnt says how many are valid.
  typedef struct packed {
    logic [1:0] cnt;
    item_t      first;
    item_t      second;
  } dec_out_t;

  function automatic logic [7:0] letter_code(input logic [7:0] c);
    logic [7:0] r;
    begin
      unique case (c)
        ChLowerN: r = CodeLf;
        ChLowerF: r = CodeFf;
        ChLowerB: r = CodeBs;
        ChLowerR: r = CodeCr;
        ChLowerT: r = CodeHt;
        default:  r = c;
      endcase
      return r;
    end
  endfunction

endpackage

// File: rtl/cesd_decode.sv
module cesd_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  output cesd_pkg::dec_out_t res
);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT1  = 2'd2,
    MODE_OCT2  = 2'd3
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] accum;
  logic [7:0] accum_next;

  logic         is_oct;
  logic [2:0]   digit;
  logic [7:0]   shifted;
  logic         plain_emit;
  cesd_pkg::item_t plain_item;
  mode_t        plain_mode;

  assign is_oct  = (in_byte >= cesd_pkg::ChDigit0) && (in_byte <= cesd_pkg::ChDigit7);
  assign digit   = in_byte[2:0];
  assign shifted = {accum[4:0], digit};

  // How a character is handled in plain copy mode.
  always_comb begin
    plain_item.data = in_byte;
    plain_item.last = 1'b0;
    plain_emit      = 1'b1;
    plain_mode      = MODE_PLAIN;
    if (in_byte == cesd_pkg::ChNul) begin
      plain_item.last = 1'b1;
    end else if (in_byte == cesd_pkg::ChBackslash) begin
      plain_emit = 1'b0;
      plain_mode = MODE_ESC;
    end
  end

  always_comb begin
    res.cnt         = 2'd0;
    res.first       = plain_item;
    res.second      = plain_item;
    mode_next       = mode;
    accum_next      = accum;
    unique case (mode)
      MODE_PLAIN: begin
        res.cnt   = {1'b0, plain_emit};
        mode_next = plain_mode;
      end
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        if (in_byte == cesd_pkg::ChNul) begin
          res.cnt         = 2'd1;
          res.first.data  = cesd_pkg::ChNul;
          res.first.last  = 1'b1;
        end else if (is_oct) begin
          accum_next = {5'd0, digit};
          mode_next  = MODE_OCT1;
        end else begin
          res.cnt        = 2'd1;
          res.first.data = cesd_pkg::letter_code(in_byte);
          res.first.last = 1'b0;
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_oct) begin
          accum_next = shifted;
          if (mode == MODE_OCT1) begin
            mode_next = MODE_OCT2;
          end else begin
            mode_next      = MODE_PLAIN;
            res.cnt        = 2'd1;
            res.first.data = shifted;
            res.first.last = 1'b0;
          end
        end else begin
          // The pending octal value goes out ahead of the ending character.
          res.first.data = accum;
          res.first.last = 1'b0;
          res.cnt        = plain_emit ? 2'd2 : 2'd1;
          mode_next      = plain_mode;
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PLAIN;
      accum <= 8'd0;
    end else if (accept) begin
      mode  <= mode_next;
      accum <= accum_next;
    end
  end

endmodule

// File: rtl/cesd_queue.sv
module cesd_queue #(
  parameter int Depth = cesd_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  cesd_pkg::dec_out_t push,
  input  logic               pop,
  output logic               not_empty,
  output logic               room_two,
  output cesd_pkg::item_t    head
);

  localparam int CntW = $clog2(Depth + 1);

  cesd_pkg::item_t entries [Depth];
  cesd_pkg::item_t entries_next [Depth];
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [CntW-1:0] base;

  assign not_empty = (count != '0);
  assign room_two  = (count <= CntW'(Depth - 2));
  assign head      = entries[0];

  always_comb begin
    base = count - CntW'(pop);
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        entries_next[i] = entries[i + 1];
      end else begin
        entries_next[i] = entries[i];
      end
      if ((push.cnt != 2'd0) && (CntW'(i) == base)) begin
        entries_next[i] = push.first;
      end
      if ((push.cnt == 2'd2) && (CntW'(i) == base + CntW'(1))) begin
        entries_next[i] = push.second;
      end
    end
    count_next = base + CntW'(push.cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < Depth; i++) begin
      entries[i] <= entries_next[i];
    end
  end

endmodule

// File: rtl/c_escape_sequence_decoder.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_byte
// out      out_valid / out_ready out_byte, end_mark
//
// Each character is decoded in the cycle it is taken; its results enter
// the result queue behind earlier ones and go out one per cycle while
// out_ready is high. A character other than an octal digit or a backslash
// that ends an octal run yields two results, which drops in_ready until
// the queue holds at most one result again.
// in_ready depends on the fill of the three-entry result queue only.
// Reset returns the decoder to plain copy mode and empties the queue.
module c_escape_sequence_decoder #(
  parameter int QueueDepth = cesd_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       end_mark
);

  cesd_pkg::dec_out_t dec_res;
  cesd_pkg::dec_out_t push;
  cesd_pkg::item_t    head;
  logic               accept;
  logic               room_two;

  assign accept = in_valid && in_ready;
  assign in_ready = room_two;

  always_comb begin
    push = dec_res;
    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  cesd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .res     (dec_res)
  );

  cesd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .room_two  (room_two),
    .head      (head)
  );

  assign out_byte = head.data;
  assign end_mark = head.last;

endmodule
